// ===== src/periodic_job_timer_table_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the periodic job timer table
// Shared clocked property templates with synchronous active-low reset.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_JOB_TIMER_TABLE_UNIT_ASSERT_SVH
`define PERIODIC_JOB_TIMER_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PJT_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pjt: same-cycle check failed");

// Next-cycle implication.
`define PJT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pjt: next-cycle check failed");

`endif

// ===== src/pjt_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pjt_pkg
// Types, request codes and sizes shared by the job timer table modules.
// ---------------------------------------------------------------------------
package pjt_pkg;

    localparam int JOB_SLOTS = 8;
    localparam int SLOT_W    = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;

    localparam logic [31:0] TICK_LIMIT = 32'h7FFF_FFFF;

    localparam logic [2:0] REQ_INIT       = 3'd0;
    localparam logic [2:0] REQ_START      = 3'd1;
    localparam logic [2:0] REQ_STOP       = 3'd2;
    localparam logic [2:0] REQ_REGISTER   = 3'd3;
    localparam logic [2:0] REQ_UNREGISTER = 3'd4;
    localparam logic [2:0] REQ_RUN        = 3'd5;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  job_id;
        logic [31:0] delay_ticks;
        logic [31:0] period_ticks;
        logic [31:0] tick_now;
    } in_item_t;

    typedef struct packed {
        logic       accepted;
        logic       fired;
        logic [7:0] fired_job;
        logic [2:0] fired_slot;
        logic       last;
    } out_item_t;

    // one memory word per slot
    typedef struct packed {
        logic [30:0] period;
        logic [30:0] delay;
        logic [31:0] remaining;
    } slot_entry_t;

    localparam int SLOT_ENTRY_W = $bits(slot_entry_t);

    typedef struct packed {
        logic              clear_all;
        logic              set;
        logic [SLOT_W-1:0] set_slot;
        logic [7:0]        set_id;
    } jobs_cmd_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] hit_slot;
        logic              free_found;
        logic [SLOT_W-1:0] free_slot;
    } jobs_lookup_t;

endpackage

// ===== src/pjt_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pjt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module pjt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/pjt_jobs.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pjt_jobs
// Job id table: per-slot ids, id match search and lowest free slot search.
// ---------------------------------------------------------------------------
module pjt_jobs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pjt_pkg::jobs_cmd_t                  cmd,
    input  logic [7:0]                          lookup_id,
    output pjt_pkg::jobs_lookup_t               lookup,
    input  logic [pjt_pkg::SLOT_W-1:0]          walk_slot,
    output logic [7:0]                          walk_job
);

    logic [7:0] job_reg [pjt_pkg::JOB_SLOTS];

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_all) begin
            for (int i = 0; i < pjt_pkg::JOB_SLOTS; i++) begin
                job_reg[i] <= 8'd0;
            end
        end else if (cmd.set) begin
            job_reg[cmd.set_slot] <= cmd.set_id;
        end
    end

    // scan downward so the lowest slot wins
    always_comb begin
        lookup = '0;
        for (int i = pjt_pkg::JOB_SLOTS - 1; i >= 0; i--) begin
            if (job_reg[i] == lookup_id) begin
                lookup.hit      = 1'b1;
                lookup.hit_slot = pjt_pkg::SLOT_W'(i);
            end
            if (job_reg[i] == 8'd0) begin
                lookup.free_found = 1'b1;
                lookup.free_slot  = pjt_pkg::SLOT_W'(i);
            end
        end
    end

    assign walk_job = job_reg[walk_slot];

endmodule

// ===== src/periodic_job_timer_table_unit.sv =====
`timescale 1ns / 1ps
// Init, stop, register, unregister and run while stopped pass through the done state
//   to the output register; start and run while running first walk every slot.
// Throughput: one request at a time; the slot walk reads one slot per cycle from the
//   slot memory (registered read), plus stalls while the result channel is full.
// Reset: job table empty, stopped, latched tick zero; slot memory is not cleared.
// ---------------------------------------------------------------------------
// periodic_job_timer_table_unit
// Periodic job timer table: request decode, slot walk over the slot memory,
// pending fired result and output register.
// ---------------------------------------------------------------------------
`include "periodic_job_timer_table_unit_assert.svh"

module periodic_job_timer_table_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pjt_pkg::in_item_t     s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pjt_pkg::out_item_t    m_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [pjt_pkg::SLOT_W-1:0] LAST_SLOT = pjt_pkg::SLOT_W'(pjt_pkg::JOB_SLOTS - 1);
    localparam logic [pjt_pkg::SLOT_W-1:0] SLOT_ONE  = pjt_pkg::SLOT_W'(1);

    logic [1:0]                 state_reg, state_next;
    logic                       running_reg, running_next;
    logic [31:0]                prev_tick_reg, prev_tick_next;
    logic [30:0]                diff_reg, diff_next;
    logic                       is_run_reg, is_run_next;
    logic                       acc_reg, acc_next;
    logic [pjt_pkg::SLOT_W-1:0] idx_reg, idx_next;
    logic                       pend_valid_reg, pend_valid_next;
    logic [7:0]                 pend_job_reg, pend_job_next;
    logic [pjt_pkg::SLOT_W-1:0] pend_slot_reg, pend_slot_next;
    logic                       m_valid_reg, m_valid_next;
    pjt_pkg::out_item_t         m_data_reg, m_data_next;

    pjt_pkg::jobs_cmd_t         jobs_cmd;
    pjt_pkg::jobs_lookup_t      lookup;
    logic [7:0]                 walk_job;

    logic                       mem_we, mem_re;
    logic [pjt_pkg::SLOT_W-1:0] mem_waddr, mem_raddr;
    pjt_pkg::slot_entry_t       mem_wdata, mem_rdata;
    logic [pjt_pkg::SLOT_ENTRY_W-1:0] mem_rdata_raw;

    logic                       accept, out_free, out_load;
    logic [31:0]                raw_diff, remain_dec;
    logic                       fire_now, stall;
    logic                       reg_ok, unreg_ok;

    pjt_jobs u_jobs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (jobs_cmd),
        .lookup_id (s_data.job_id),
        .lookup    (lookup),
        .walk_slot (idx_reg),
        .walk_job  (walk_job)
    );

    pjt_ram #(
        .WIDTH (pjt_pkg::SLOT_ENTRY_W),
        .DEPTH (pjt_pkg::JOB_SLOTS)
    ) u_slot_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata_raw)
    );

    assign mem_rdata = pjt_pkg::slot_entry_t'(mem_rdata_raw);

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign raw_diff   = s_data.tick_now - prev_tick_reg;
    assign remain_dec = mem_rdata.remaining - {1'b0, diff_reg};
    assign fire_now   = (state_reg == ST_WALK) && is_run_reg && (walk_job != 8'd0)
                        && ((remain_dec == 32'd0) || remain_dec[31]);
    assign stall      = fire_now && pend_valid_reg && !out_free;

    assign reg_ok   = (s_data.job_id != 8'd0) && !s_data.delay_ticks[31]
                      && !s_data.period_ticks[31] && !lookup.hit && lookup.free_found;
    assign unreg_ok = (s_data.job_id != 8'd0) && lookup.hit;

    always_comb begin
        state_next      = state_reg;
        running_next    = running_reg;
        prev_tick_next  = prev_tick_reg;
        diff_next       = diff_reg;
        is_run_next     = is_run_reg;
        acc_next        = acc_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_job_next   = pend_job_reg;
        pend_slot_next  = pend_slot_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        out_load        = 1'b0;
        jobs_cmd        = '0;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = mem_rdata;
        mem_re          = 1'b0;
        mem_raddr       = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_DONE;
                    acc_next   = 1'b1;
                    idx_next   = '0;
                    case (s_data.req_type)
                        pjt_pkg::REQ_INIT: begin
                            jobs_cmd.clear_all = 1'b1;
                            prev_tick_next     = 32'd0;
                            running_next       = 1'b0;
                        end
                        pjt_pkg::REQ_START: begin
                            prev_tick_next = s_data.tick_now;
                            running_next   = 1'b1;
                            is_run_next    = 1'b0;
                            mem_re         = 1'b1;
                            state_next     = ST_WALK;
                        end
                        pjt_pkg::REQ_STOP: begin
                            running_next = 1'b0;
                        end
                        pjt_pkg::REQ_REGISTER: begin
                            acc_next = reg_ok;
                            if (reg_ok) begin
                                jobs_cmd.set       = 1'b1;
                                jobs_cmd.set_slot  = lookup.free_slot;
                                jobs_cmd.set_id    = s_data.job_id;
                                mem_we             = 1'b1;
                                mem_waddr          = lookup.free_slot;
                                mem_wdata.period   = s_data.period_ticks[30:0];
                                mem_wdata.delay    = s_data.delay_ticks[30:0];
                                mem_wdata.remaining = s_data.delay_ticks;
                            end
                        end
                        pjt_pkg::REQ_UNREGISTER: begin
                            acc_next = unreg_ok;
                            if (unreg_ok) begin
                                jobs_cmd.set      = 1'b1;
                                jobs_cmd.set_slot = lookup.hit_slot;
                                jobs_cmd.set_id   = 8'd0;
                            end
                        end
                        pjt_pkg::REQ_RUN: begin
                            if (running_reg) begin
                                // saturate the wrapped tick difference
                                diff_next      = raw_diff[31] ? pjt_pkg::TICK_LIMIT[30:0]
                                                              : raw_diff[30:0];
                                prev_tick_next = s_data.tick_now;
                                is_run_next    = 1'b1;
                                mem_re         = 1'b1;
                                state_next     = ST_WALK;
                            end
                        end
                        default: begin
                            acc_next = 1'b0;
                        end
                    endcase
                end
            end

            ST_WALK: begin
                if (!stall) begin
                    if (!is_run_reg) begin
                        mem_we              = 1'b1;
                        mem_wdata.remaining = {1'b0, mem_rdata.delay};
                    end else if (walk_job != 8'd0) begin
                        mem_we              = 1'b1;
                        mem_wdata.remaining = fire_now ? {1'b0, mem_rdata.period}
                                                       : remain_dec;
                    end
                    if (fire_now) begin
                        // push the older fired result, keep the newest one back
                        if (pend_valid_reg) begin
                            out_load                = 1'b1;
                            m_valid_next            = 1'b1;
                            m_data_next.accepted    = 1'b1;
                            m_data_next.fired       = 1'b1;
                            m_data_next.fired_job   = pend_job_reg;
                            m_data_next.fired_slot  = 3'(pend_slot_reg);
                            m_data_next.last        = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_job_next   = walk_job;
                        pend_slot_next  = idx_reg;
                    end
                    if (idx_reg == LAST_SLOT) begin
                        state_next = ST_DONE;
                    end else begin
                        idx_next  = idx_reg + SLOT_ONE;
                        mem_re    = 1'b1;
                        mem_raddr = idx_reg + SLOT_ONE;
                    end
                end
            end

            ST_DONE: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    if (pend_valid_reg) begin
                        m_data_next.accepted   = 1'b1;
                        m_data_next.fired      = 1'b1;
                        m_data_next.fired_job  = pend_job_reg;
                        m_data_next.fired_slot = 3'(pend_slot_reg);
                    end else begin
                        m_data_next.accepted   = acc_reg;
                        m_data_next.fired      = 1'b0;
                        m_data_next.fired_job  = 8'd0;
                        m_data_next.fired_slot = 3'd0;
                    end
                    m_data_next.last = 1'b1;
                    pend_valid_next  = 1'b0;
                    state_next       = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            running_reg    <= 1'b0;
            prev_tick_reg  <= 32'd0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            is_run_reg     <= 1'b0;
            acc_reg        <= 1'b0;
            idx_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            running_reg    <= running_next;
            prev_tick_reg  <= prev_tick_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            is_run_reg     <= is_run_next;
            acc_reg        <= acc_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        diff_reg      <= diff_next;
        pend_job_reg  <= pend_job_next;
        pend_slot_reg <= pend_slot_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `PJT_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, accept, state_reg != ST_IDLE)
    `PJT_ASSERT_NOW(a_no_pending_in_idle, aclk, aresetn, state_reg == ST_IDLE, !pend_valid_reg)
    `PJT_ASSERT_NOW(a_walk_addr_split, aclk, aresetn, mem_we && mem_re, mem_waddr != mem_raddr)
    `PJT_ASSERT_NOW(a_load_only_when_free, aclk, aresetn, out_load, out_free)

endmodule
